// ===== rtl/spt_pkg.sv =====
// ---------------------------------------------------------------------------
// spt_pkg: shared types and constants of the SYN probe tracker
// Request and result layouts, register indexes, codes, controller/datapath
// command and status bundles.
// ---------------------------------------------------------------------------
package spt_pkg;

  localparam int SLOTS_DEF = 32;

  // register reset values
  localparam logic [15:0] BASE_RST    = 16'd20000;
  localparam logic [15:0] SPAN_RST    = 16'd20000;
  localparam logic [3:0]  RETRIES_RST = 4'd2;
  localparam logic [15:0] TIMEOUT_RST = 16'd200;
  localparam logic [5:0]  MAXOUT_RST  = 6'd32;
  localparam logic [31:0] SEED_RST    = 32'd1;

  // register indexes
  localparam logic [2:0] REG_BASE    = 3'd0;
  localparam logic [2:0] REG_SPAN    = 3'd1;
  localparam logic [2:0] REG_RETRIES = 3'd2;
  localparam logic [2:0] REG_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_MAXOUT  = 3'd4;
  localparam logic [2:0] REG_SEED    = 3'd5;

  // operation codes
  localparam logic [1:0] OP_LAUNCH   = 2'd0;
  localparam logic [1:0] OP_RESPONSE = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PROBE  = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_REFUSE = 2'd2;

  // port states
  localparam logic [1:0] ST_OPEN       = 2'd0;
  localparam logic [1:0] ST_CLOSED     = 2'd1;
  localparam logic [1:0] ST_UNFILTERED = 2'd2;
  localparam logic [1:0] ST_FILTERED   = 2'd3;

  // TCP flag bits
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] target_port;
    logic [15:0] resp_source_port;
    logic [15:0] resp_dest_port;
    logic [31:0] resp_ack;
    logic [7:0]  resp_flags;
    logic [15:0] resp_window;
    logic [7:0]  resp_ttl;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] source_port;
    logic [15:0] target_port_out;
    logic [31:0] seq;
    logic [1:0]  port_state;
    logic [3:0]  attempt;
    logic [7:0]  ttl_out;
    logic [15:0] window_out;
    logic [31:0] rtt_ticks;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    RES_PROBE  = 2'd0,
    RES_REFUSE = 2'd1,
    RES_REPORT = 2'd2,
    RES_FILTER = 2'd3
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     ld_item;
    logic     tick_now;
    logic     idx_clr;
    logic     idx_inc;
    logic     aidx_clr;
    logic     aidx_inc;
    logic     rd_alloc;
    logic     alloc_init;
    logic     alloc_next;
    logic     clr_valid;
    logic     capture_free;
    logic     capture_due;
    logic     fill;
    logic     push;
    res_sel_t res_sel;
    logic     flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       full;
    logic       idx_last;
    logic       aidx_last;
    logic       valid_at_idx;
    logic       tries_zero;
    logic       port_hit;
    logic       resp_key;
    logic       resp_tgt;
    logic       resp_has_result;
    logic       due;
    logic       retry_ok;
  } sts_t;

endpackage

// ===== rtl/spt_datapath.sv =====
// ---------------------------------------------------------------------------
// spt_datapath: slot table, counters, registers and result staging
// Holds the slot memory, valid bits, time, port counter, sequence generator
// and configuration, and carries out the controller's commands.
// ---------------------------------------------------------------------------
module spt_datapath #(
  parameter int SLOTS = spt_pkg::SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  spt_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  spt_pkg::cmd_t     cmd,
  output spt_pkg::sts_t     sts,
  output logic              out_valid,
  output spt_pkg::out_item_t out_item
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int LIM_W = 9;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
  localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(SLOTS);

  typedef struct packed {
    logic [15:0] sp;
    logic [15:0] tp;
    logic [3:0]  att;
    logic [31:0] seq;
    logic [31:0] started;
    logic [31:0] deadline;
  } slot_t;

  // configuration
  logic [15:0] base_r, span_r, timeout_r;
  logic [3:0]  retries_r;
  logic [5:0]  maxout_r;

  // state
  slot_t             mem [SLOTS];
  slot_t             rdata_r;
  logic [SLOTS-1:0]  valid_r;
  logic [CNT_W-1:0]  count_r;
  logic [31:0]       now_r, gen_r;
  logic [15:0]       np_r, cand_r, tries_r;
  logic [IDX_W-1:0]  idx_r, aidx_r, w_slot_r;
  logic [15:0]       w_tp_r;
  logic [3:0]        w_att_r;
  logic              w_retry_r;
  spt_pkg::in_item_t item_r;
  spt_pkg::out_item_t pend_r, out_r;
  logic              pend_v_r, out_valid_r;

  // port counter step
  logic [15:0] np_step;
  always_comb begin
    np_step = np_r + 16'd1;
    if (np_step < base_r || {1'b0, np_step} >= ({1'b0, base_r} + {1'b0, span_r}))
      np_step = base_r;
  end

  // xorshift32 step
  logic [31:0] x1, x2, gen_nxt;
  assign x1      = gen_r ^ (gen_r << 13);
  assign x2      = x1 ^ (x1 >> 17);
  assign gen_nxt = x2 ^ (x2 << 5);

  // new slot contents
  logic [3:0]  natt;
  logic [20:0] tmo_mul;
  slot_t       wslot;
  assign natt    = w_retry_r ? (w_att_r + 4'd1) : w_att_r;
  assign tmo_mul = timeout_r * ({1'b0, natt} + 5'd1);
  always_comb begin
    wslot.sp       = cand_r;
    wslot.tp       = w_tp_r;
    wslot.att      = natt;
    wslot.seq      = gen_nxt;
    wslot.started  = now_r;
    wslot.deadline = now_r + {11'd0, tmo_mul};
  end

  // response classification
  logic [7:0]  fl;
  logic [1:0]  resp_st;
  logic [31:0] dlt;
  assign fl = item_r.resp_flags;
  always_comb begin
    if (fl[spt_pkg::FLAG_SYN] && fl[spt_pkg::FLAG_ACK])
      resp_st = spt_pkg::ST_OPEN;
    else if (fl[spt_pkg::FLAG_RST])
      resp_st = (item_r.resp_ack == rdata_r.seq + 32'd1 || item_r.resp_ack == rdata_r.seq)
                ? spt_pkg::ST_CLOSED : spt_pkg::ST_UNFILTERED;
    else
      resp_st = spt_pkg::ST_UNFILTERED;
  end
  assign dlt = now_r - rdata_r.deadline;

  // occupancy limit
  logic [LIM_W-1:0] lim;
  always_comb begin
    lim = {3'd0, maxout_r};
    if (lim == '0) lim = LIM_W'(1);
    if (lim > LIM_MAX) lim = LIM_MAX;
  end

  // status
  always_comb begin
    sts.op              = item_r.operation;
    sts.full            = LIM_W'(count_r) >= lim;
    sts.idx_last        = idx_r == IDX_LAST;
    sts.aidx_last       = aidx_r == IDX_LAST;
    sts.valid_at_idx    = valid_r[idx_r];
    sts.tries_zero      = tries_r == 16'd0;
    sts.port_hit        = valid_r[aidx_r] && rdata_r.sp == cand_r;
    sts.resp_key        = valid_r[idx_r] && rdata_r.sp == item_r.resp_dest_port;
    sts.resp_tgt        = rdata_r.tp == item_r.resp_source_port;
    sts.resp_has_result = fl[spt_pkg::FLAG_RST] || fl[spt_pkg::FLAG_ACK];
    sts.due             = valid_r[idx_r] && !dlt[31];
    sts.retry_ok        = rdata_r.att < retries_r;
  end

  // result being produced
  spt_pkg::out_item_t res;
  always_comb begin
    res = '0;
    case (cmd.res_sel)
      spt_pkg::RES_PROBE: begin
        res.kind            = spt_pkg::KIND_PROBE;
        res.source_port     = cand_r;
        res.target_port_out = w_tp_r;
        res.seq             = gen_nxt;
        res.attempt         = natt;
      end
      spt_pkg::RES_REFUSE: begin
        res.kind            = spt_pkg::KIND_REFUSE;
        res.target_port_out = item_r.target_port;
      end
      spt_pkg::RES_REPORT: begin
        res.kind            = spt_pkg::KIND_REPORT;
        res.target_port_out = rdata_r.tp;
        res.port_state      = resp_st;
        res.attempt         = rdata_r.att;
        res.ttl_out         = item_r.resp_ttl;
        res.window_out      = item_r.resp_window;
        res.rtt_ticks       = now_r - rdata_r.started;
      end
      spt_pkg::RES_FILTER: begin
        // straight from the slot when it is captured in this same cycle
        res.kind            = spt_pkg::KIND_REPORT;
        res.target_port_out = cmd.capture_due ? rdata_r.tp : w_tp_r;
        res.port_state      = spt_pkg::ST_FILTERED;
        res.attempt         = cmd.capture_due ? rdata_r.att : w_att_r;
      end
      default: res = '0;
    endcase
  end

  // held result with its last flag
  spt_pkg::out_item_t pend_fin;
  always_comb begin
    pend_fin      = pend_r;
    pend_fin.last = cmd.flush;
  end

  // slot memory: one write, one registered read
  logic [IDX_W-1:0] rd_addr;
  assign rd_addr = cmd.rd_alloc ? aidx_r : idx_r;
  always_ff @(posedge clk) begin
    rdata_r <= mem[rd_addr];
    if (cmd.fill) mem[w_slot_r] <= wslot;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.ld_item) item_r <= in_item;
    if (cmd.alloc_next) cand_r <= np_r;
    if (cmd.capture_free) begin
      w_slot_r  <= idx_r;
      w_tp_r    <= item_r.target_port;
      w_att_r   <= 4'd0;
      w_retry_r <= 1'b0;
    end
    if (cmd.capture_due) begin
      w_slot_r  <= idx_r;
      w_tp_r    <= rdata_r.tp;
      w_att_r   <= rdata_r.att;
      w_retry_r <= 1'b1;
    end
    if (cmd.push) pend_r <= res;
    if ((cmd.push && pend_v_r) || cmd.flush) out_r <= pend_fin;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= spt_pkg::BASE_RST;
      span_r      <= spt_pkg::SPAN_RST;
      retries_r   <= spt_pkg::RETRIES_RST;
      timeout_r   <= spt_pkg::TIMEOUT_RST;
      maxout_r    <= spt_pkg::MAXOUT_RST;
      np_r        <= spt_pkg::BASE_RST;
      gen_r       <= spt_pkg::SEED_RST;
      valid_r     <= '0;
      count_r     <= '0;
      now_r       <= '0;
      tries_r     <= '0;
      idx_r       <= '0;
      aidx_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spt_pkg::REG_BASE: begin
            base_r <= cfg_wdata[15:0];
            np_r   <= cfg_wdata[15:0];
          end
          spt_pkg::REG_SPAN:    span_r    <= cfg_wdata[15:0];
          spt_pkg::REG_RETRIES: retries_r <= cfg_wdata[3:0];
          spt_pkg::REG_TIMEOUT: timeout_r <= cfg_wdata[15:0];
          spt_pkg::REG_MAXOUT:  maxout_r  <= cfg_wdata[5:0];
          spt_pkg::REG_SEED:    gen_r     <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.tick_now) now_r <= now_r + 32'd1;
      if (cmd.idx_clr) idx_r <= '0;
      if (cmd.idx_inc) idx_r <= idx_r + IDX_W'(1);
      if (cmd.aidx_clr) aidx_r <= '0;
      if (cmd.aidx_inc) aidx_r <= aidx_r + IDX_W'(1);
      if (cmd.alloc_init) tries_r <= (span_r == 16'd0) ? 16'd1 : span_r;
      if (cmd.alloc_next) begin
        np_r    <= np_step;
        tries_r <= tries_r - 16'd1;
      end
      // valid bits and occupancy; clear and fill never share a cycle
      if (cmd.clr_valid) begin
        valid_r[idx_r] <= 1'b0;
        count_r        <= count_r - CNT_W'(1);
      end
      if (cmd.fill) begin
        valid_r[w_slot_r] <= 1'b1;
        count_r           <= count_r + CNT_W'(1);
        gen_r             <= gen_nxt;
      end
      // one result held back so the final one can carry last
      out_valid_r <= (cmd.push || cmd.flush) && pend_v_r;
      if (cmd.push)       pend_v_r <= 1'b1;
      else if (cmd.flush) pend_v_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/spt_ctrl.sv =====
// ---------------------------------------------------------------------------
// spt_ctrl: sequencer of the SYN probe tracker
// Walks the slot table for launch, response and tick requests and runs the
// port allocation search as a subroutine.
// ---------------------------------------------------------------------------
module spt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spt_pkg::sts_t sts,
  output spt_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_FREE   = 10'b0000000100,
    S_RD     = 10'b0000001000,
    S_CMP    = 10'b0000010000,
    S_NEXT   = 10'b0000100000,
    S_ALLOC  = 10'b0001000000,
    S_ARD    = 10'b0010000000,
    S_ACMP   = 10'b0100000000,
    S_FLUSH  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_launch;

  assign is_launch = sts.op == spt_pkg::OP_LAUNCH;
  assign busy      = state_r != S_IDLE;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.res_sel = spt_pkg::RES_PROBE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.ld_item = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.idx_clr = 1'b1;
        case (sts.op)
          spt_pkg::OP_LAUNCH: begin
            if (sts.full) begin
              cmd.push    = 1'b1;
              cmd.res_sel = spt_pkg::RES_REFUSE;
              state_nxt   = S_FLUSH;
            end else begin
              state_nxt = S_FREE;
            end
          end
          spt_pkg::OP_RESPONSE: state_nxt = S_RD;
          spt_pkg::OP_TICK: begin
            cmd.tick_now = 1'b1;
            state_nxt    = S_RD;
          end
          default: state_nxt = S_FLUSH;
        endcase
      end
      // first free slot; one exists whenever the table is under its limit
      S_FREE: begin
        if (!sts.valid_at_idx) begin
          cmd.capture_free = 1'b1;
          cmd.alloc_init   = 1'b1;
          state_nxt        = S_ALLOC;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (sts.op == spt_pkg::OP_RESPONSE) begin
          if (sts.resp_key) begin
            if (sts.resp_tgt) begin
              cmd.clr_valid = 1'b1;
              if (sts.resp_has_result) begin
                cmd.push    = 1'b1;
                cmd.res_sel = spt_pkg::RES_REPORT;
              end
            end
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_NEXT;
          end
        end else begin
          if (sts.due) begin
            cmd.clr_valid   = 1'b1;
            cmd.capture_due = 1'b1;
            if (sts.retry_ok) begin
              cmd.alloc_init = 1'b1;
              state_nxt      = S_ALLOC;
            end else begin
              cmd.push    = 1'b1;
              cmd.res_sel = spt_pkg::RES_FILTER;
              state_nxt   = S_NEXT;
            end
          end else begin
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (sts.idx_last) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_RD;
        end
      end
      // allocation: take a candidate, then check it against every slot
      S_ALLOC: begin
        if (sts.tries_zero) begin
          cmd.push    = 1'b1;
          cmd.res_sel = is_launch ? spt_pkg::RES_REFUSE : spt_pkg::RES_FILTER;
          state_nxt   = is_launch ? S_FLUSH : S_NEXT;
        end else begin
          cmd.alloc_next = 1'b1;
          cmd.aidx_clr   = 1'b1;
          state_nxt      = S_ARD;
        end
      end
      S_ARD: begin
        cmd.rd_alloc = 1'b1;
        state_nxt    = S_ACMP;
      end
      S_ACMP: begin
        if (sts.port_hit) begin
          state_nxt = S_ALLOC;
        end else if (sts.aidx_last) begin
          cmd.fill    = 1'b1;
          cmd.push    = 1'b1;
          cmd.res_sel = spt_pkg::RES_PROBE;
          state_nxt   = is_launch ? S_FLUSH : S_NEXT;
        end else begin
          cmd.aidx_inc = 1'b1;
          state_nxt    = S_ARD;
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== rtl/syn_probe_tracker.sv =====
// ---------------------------------------------------------------------------
// syn_probe_tracker: outstanding SYN probe table
// Launch, response and tick requests against a table of SLOTS probe slots.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// while the request is worked on and falls in the cycle that shows its final
// result. Results appear on out_item for one cycle each, marked by out_valid,
// and cannot be stalled: the receiver must take each one as it comes;
// out_item.last marks the final result of a request. One slot memory read
// port does all the matching: a table walk steps through S_RD, S_CMP and
// S_NEXT for each slot, a port check through S_ARD and S_ACMP. There is no
// clearing pass after reset.
// ---------------------------------------------------------------------------
module syn_probe_tracker #(
  parameter int SLOTS = spt_pkg::SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  spt_pkg::in_item_t  in_item,
  output logic               out_valid,
  output spt_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  spt_pkg::cmd_t cmd;
  spt_pkg::sts_t sts;

  spt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  spt_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
